/* hw/rtl/hsv_value_invert_pixel_top_assert.svh */
// Assertion macros shared by the value inversion block.
`ifndef HSV_VALUE_INVERT_PIXEL_TOP_ASSERT_SVH
`define HSV_VALUE_INVERT_PIXEL_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define HSV_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hsv assertion failed");
// Expression must never be true outside reset.
`define HSV_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("hsv forbidden condition seen");
`else
`define HSV_ASSERT(lbl, clk, rstn, prop)
`define HSV_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* hw/rtl/hsv_inv_pkg.sv */
// Types and constants for the HSV value inversion block.
package hsv_inv_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;
  // Reciprocal precision: 16-bit numerators, 8-bit divisors.
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned NumW       = 2 * ChanW;

  localparam logic [ChanW-1:0]  ChanMax     = 8'd255;
  localparam logic [PaddrW-1:0] AddrAlphaEn = 3'd0;

  // Which channel holds the maximum, or a grey pixel.
  typedef enum logic [1:0] {
    SEL_GREY,
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_e;

  typedef struct packed {
    logic [ChanW-1:0] red_in;
    logic [ChanW-1:0] green_in;
    logic [ChanW-1:0] blue_in;
    logic [ChanW-1:0] alpha_in;
    logic             row_end;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red_out;
    logic [ChanW-1:0] green_out;
    logic [ChanW-1:0] blue_out;
    logic [ChanW-1:0] alpha_out;
    logic             row_end_out;
  } pix_out_t;

endpackage

/* hw/rtl/hsv_value_invert_pixel_top.sv */
// HSV value inversion of one RGB(A) pixel per clock, four-stage pipeline.
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-----------------
//  pixel in  | in        | start_i, busy_o          | pixel_i (pix_in_t)
//  result    | out       | result_valid_o strobe    | result_o (pix_out_t)
//  config    | in/out    | APB psel/penable/pready  | pwdata_i / prdata_o
//
// One pixel is accepted every cycle; busy_o stays low.
// Each result is registered through the stages in order:
// max/min select, numerator multiply, reciprocal multiply, output assembly.
// Division by the channel maximum uses a 256-entry reciprocal table and a multiply.
// Reset clears the valid bits and the alpha enable; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`include "hsv_value_invert_pixel_top_assert.svh"

module hsv_value_invert_pixel_top
  import hsv_inv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  pix_in_t           pixel_i,
  output logic              result_valid_o,
  output pix_out_t          result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  // Reciprocal table: ceil(2^RecipShift / v), exact floor division for 16-bit numerators.
  logic [RecipW-1:0] recip_tab [2**ChanW];

  for (genvar gi = 0; gi < 2**ChanW; gi++) begin : g_recip
    localparam longint unsigned Div = (gi == 0) ? 1 : gi;
    localparam longint unsigned Rc  =
      (gi == 0) ? 0 : (((longint'(1) << RecipShift) + Div - 1) / Div);
    assign recip_tab[gi] = RecipW'(Rc);
  end

  // Configuration register, decoded on the word address bits.
  logic alpha_en_q, alpha_en_d;
  logic cfg_wr;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = (paddr[PaddrW-1:2] == AddrAlphaEn[PaddrW-1:2]);

  always_comb begin
    alpha_en_d = alpha_en_q;
    if (cfg_wr && cfg_hit) begin
      alpha_en_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata = {{(PdataW-1){1'b0}}, alpha_en_q};
    end
  end

  assign busy_o = 1'b0;

  // Stage 1: maximum, minimum and the channel that keeps 255 - v.
  logic [ChanW-1:0] v_c, m_c;
  max_sel_e         sel_c;
  logic [ChanW-1:0] opa_c, opb_c;

  always_comb begin
    v_c = pixel_i.red_in;
    if (pixel_i.green_in > v_c) begin
      v_c = pixel_i.green_in;
    end
    if (pixel_i.blue_in > v_c) begin
      v_c = pixel_i.blue_in;
    end
    m_c = pixel_i.red_in;
    if (pixel_i.green_in < m_c) begin
      m_c = pixel_i.green_in;
    end
    if (pixel_i.blue_in < m_c) begin
      m_c = pixel_i.blue_in;
    end
    if ((v_c == '0) || (v_c == m_c)) begin
      sel_c = SEL_GREY;
    end else if (pixel_i.red_in == v_c) begin
      sel_c = SEL_RED;
    end else if (pixel_i.green_in == v_c) begin
      sel_c = SEL_GREEN;
    end else begin
      sel_c = SEL_BLUE;
    end
    // The two channels that get scaled, in red-green-blue order.
    opa_c = (sel_c == SEL_RED) ? pixel_i.green_in : pixel_i.red_in;
    opb_c = (sel_c == SEL_BLUE) ? pixel_i.green_in : pixel_i.blue_in;
  end

  logic             s1_valid_q;
  logic [ChanW-1:0] s1_v_q, s1_inv_q, s1_opa_q, s1_opb_q, s1_alpha_q;
  max_sel_e         s1_sel_q;
  logic             s1_last_q;

  // Stage 2: numerators and reciprocal lookup.
  logic [NumW-1:0] num_a_c, num_b_c;

  assign num_a_c = NumW'(s1_inv_q) * NumW'(s1_opa_q) + NumW'(s1_v_q >> 1);
  assign num_b_c = NumW'(s1_inv_q) * NumW'(s1_opb_q) + NumW'(s1_v_q >> 1);

  logic              s2_valid_q;
  logic [NumW-1:0]   s2_num_a_q, s2_num_b_q;
  logic [RecipW-1:0] s2_recip_q;
  logic [ChanW-1:0]  s2_inv_q, s2_alpha_q;
  max_sel_e          s2_sel_q;
  logic              s2_last_q;

  // Stage 3: multiply by the reciprocal; the quotient sits above the shift.
  logic [NumW+RecipW-1:0] prod_a_c, prod_b_c;

  assign prod_a_c = (NumW+RecipW)'(s2_num_a_q) * (NumW+RecipW)'(s2_recip_q);
  assign prod_b_c = (NumW+RecipW)'(s2_num_b_q) * (NumW+RecipW)'(s2_recip_q);

  logic             s3_valid_q;
  logic [ChanW-1:0] s3_qa_q, s3_qb_q, s3_inv_q, s3_alpha_q;
  max_sel_e         s3_sel_q;
  logic             s3_last_q;

  // Stage 4: put the inverted value and quotients on their channels.
  pix_out_t res_c;

  always_comb begin
    res_c.alpha_out   = s3_alpha_q;
    res_c.row_end_out = s3_last_q;
    case (s3_sel_q)
      SEL_RED: begin
        res_c.red_out   = s3_inv_q;
        res_c.green_out = s3_qa_q;
        res_c.blue_out  = s3_qb_q;
      end
      SEL_GREEN: begin
        res_c.red_out   = s3_qa_q;
        res_c.green_out = s3_inv_q;
        res_c.blue_out  = s3_qb_q;
      end
      SEL_BLUE: begin
        res_c.red_out   = s3_qa_q;
        res_c.green_out = s3_qb_q;
        res_c.blue_out  = s3_inv_q;
      end
      default: begin
        res_c.red_out   = s3_inv_q;
        res_c.green_out = s3_inv_q;
        res_c.blue_out  = s3_inv_q;
      end
    endcase
  end

  // Control registers: valid bits and the alpha enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_en_q     <= 1'b0;
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      s3_valid_q     <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      alpha_en_q     <= alpha_en_d;
      s1_valid_q     <= start_i && !busy_o;
      s2_valid_q     <= s1_valid_q;
      s3_valid_q     <= s2_valid_q;
      result_valid_o <= s3_valid_q;
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk_i) begin
    s1_v_q     <= v_c;
    s1_inv_q   <= ChanMax - v_c;
    s1_opa_q   <= opa_c;
    s1_opb_q   <= opb_c;
    s1_sel_q   <= sel_c;
    s1_alpha_q <= alpha_en_q ? pixel_i.alpha_in : '0;
    s1_last_q  <= pixel_i.row_end;

    s2_num_a_q <= num_a_c;
    s2_num_b_q <= num_b_c;
    s2_recip_q <= recip_tab[s1_v_q];
    s2_inv_q   <= s1_inv_q;
    s2_sel_q   <= s1_sel_q;
    s2_alpha_q <= s1_alpha_q;
    s2_last_q  <= s1_last_q;

    s3_qa_q    <= prod_a_c[RecipShift +: ChanW];
    s3_qb_q    <= prod_b_c[RecipShift +: ChanW];
    s3_inv_q   <= s2_inv_q;
    s3_sel_q   <= s2_sel_q;
    s3_alpha_q <= s2_alpha_q;
    s3_last_q  <= s2_last_q;

    result_o   <= res_c;
  end

  // Every transaction yields one result, and every result comes from a transaction.
  `HSV_ASSERT(a_latency_fwd, clk_i, rst_ni, (start_i && !busy_o) |-> ##4 result_valid_o)
  `HSV_ASSERT(a_latency_bwd, clk_i, rst_ni, result_valid_o |-> $past(start_i && !busy_o, 4))

endmodule
